// ----- rtl/slfq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfq_pkg
// shared types, sizes and codes of the serial display frame queue
// ----------------------------------------------------------------------------
package slfq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned ENTRY_W     = DATA_W + 1;
  localparam int unsigned FRAME_BITS  = DATA_W + 2;
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BITS - 1);

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_TICK    = 1'b1
  } op_e;

  typedef struct packed {
    logic enq;
    logic fetch;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last_bit;
    logic out_free;
  } status_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- rtl/slfq_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfq_if
// handshake channels for queue requests and serial frame results
// ----------------------------------------------------------------------------
interface slfq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [slfq_pkg::DATA_W-1:0] data_byte;
  logic                        is_command;

  modport source (output valid, output operation, output data_byte, output is_command,
                  input ready);
  modport sink   (input valid, input operation, input data_byte, input is_command,
                  output ready);
endinterface

interface slfq_out_if;
  logic                       valid;
  logic                       ready;
  logic                       serial_bit;
  logic [slfq_pkg::POS_W-1:0] bit_position;
  logic                       frame_end;
  logic                       dropped;

  modport source (output valid, output serial_bit, output bit_position, output frame_end,
                  output dropped, input ready);
  modport sink   (input valid, input serial_bit, input bit_position, input frame_end,
                  input dropped, output ready);
endinterface

// ----- rtl/serial_lcd_frame_queue.sv -----
`timescale 1ns / 1ps
// an enqueue status result is offered in the cycle after its transaction
// a tick on a non-empty queue offers its first bit after the fetch and load states,
// then one bit per cycle from the frame shift register while the sink takes them
// new requests are refused while a tick's frame is sent; an enqueue or an empty tick leaves the queue idle
// reset: pointers cleared so the queue is empty; entries are not cleared
// ----------------------------------------------------------------------------
// serial_lcd_frame_queue
// queue of tagged display bytes sent as ten-bit serial frames
// ----------------------------------------------------------------------------
module serial_lcd_frame_queue (
  input  logic     clk_i,
  input  logic     rst_ni,
  slfq_in_if.sink  in_i,
  slfq_out_if.source out_o
);

  slfq_pkg::cmd_t    cmd;
  slfq_pkg::status_t status;

  slfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_op_i    (in_i.operation),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slfq_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_byte_i    (in_i.data_byte),
    .is_command_i   (in_i.is_command),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .serial_bit_o   (out_o.serial_bit),
    .bit_position_o (out_o.bit_position),
    .frame_end_o    (out_o.frame_end),
    .dropped_o      (out_o.dropped)
  );

endmodule

// ----- rtl/slfq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfq_datapath
// ring queue storage, pointers, frame shifter and result register
// ----------------------------------------------------------------------------
module slfq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slfq_pkg::cmd_t                cmd_i,
  output slfq_pkg::status_t             status_o,
  input  logic [slfq_pkg::DATA_W-1:0]   data_byte_i,
  input  logic                          is_command_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          serial_bit_o,
  output logic [slfq_pkg::POS_W-1:0]    bit_position_o,
  output logic                          frame_end_o,
  output logic                          dropped_o
);

  logic [slfq_pkg::ENTRY_W-1:0]    mem [slfq_pkg::QUEUE_DEPTH];
  logic [slfq_pkg::ENTRY_W-1:0]    rd_q;
  logic [slfq_pkg::PTR_W-1:0]      rp_q, rp_d, wp_q, wp_d;
  logic [slfq_pkg::FRAME_BITS-1:0] frame_q;
  logic [slfq_pkg::POS_W-1:0]      pos_q;
  logic [slfq_pkg::POS_W-1:0]      pos_out_q;
  logic                            out_valid_q, out_valid_d;
  logic                            bit_q, end_q, drop_q;
  logic                            full, empty, out_free, write_en;

  assign empty    = (rp_q == wp_q);
  assign full     = (slfq_pkg::next_ptr(wp_q) == rp_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign write_en = cmd_i.enq && !full;

  assign status_o.empty    = empty;
  assign status_o.full     = full;
  assign status_o.last_bit = (pos_q == slfq_pkg::LAST_POS);
  assign status_o.out_free = out_free;

  always_comb begin
    wp_d = write_en ? slfq_pkg::next_ptr(wp_q) : wp_q;
    rp_d = cmd_i.load ? slfq_pkg::next_ptr(rp_q) : rp_q;
    if (cmd_i.enq || cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (write_en) begin
      mem[wp_q] <= {is_command_i, data_byte_i};
    end
    if (cmd_i.fetch) begin
      rd_q <= mem[rp_q];
    end
  end

  // frame shifter and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q <= {rd_q[slfq_pkg::DATA_W], 1'b0, rd_q[slfq_pkg::DATA_W-1:0]};
      pos_q   <= '0;
    end else if (cmd_i.emit) begin
      frame_q <= {frame_q[slfq_pkg::FRAME_BITS-2:0], 1'b0};
      pos_q   <= pos_q + 1'b1;
    end
    if (cmd_i.enq) begin
      bit_q     <= 1'b0;
      end_q     <= 1'b0;
      drop_q    <= full;
      pos_out_q <= '0;
    end else if (cmd_i.emit) begin
      bit_q     <= frame_q[slfq_pkg::FRAME_BITS-1];
      end_q     <= (pos_q == slfq_pkg::LAST_POS);
      drop_q    <= 1'b0;
      pos_out_q <= pos_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign serial_bit_o   = bit_q;
  assign bit_position_o = pos_out_q;
  assign frame_end_o    = end_q;
  assign dropped_o      = drop_q;

`ifndef ASSERT_OFF
  a_full_holds_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.enq && full) |=> $stable(wp_q))
    else $error("write pointer moved on a full queue");

  a_last_bit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && pos_q == slfq_pkg::LAST_POS) |=> (out_valid_q && end_q))
    else $error("last frame bit without frame end");

  a_no_drop_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(end_q && drop_q))
    else $error("frame end and dropped flag together");
`endif

endmodule

// ----- rtl/slfq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfq_ctrl
// sequencer for enqueue, fetch and bit-by-bit frame transmission
// ----------------------------------------------------------------------------
module slfq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_op_i,
  input  slfq_pkg::status_t status_i,
  output slfq_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FRAME
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == slfq_pkg::OP_ENQUEUE) begin
            cmd_o.enq = 1'b1;
          end else if (!status_i.empty) begin
            cmd_o.fetch = 1'b1;
            state_d     = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd_o.load = 1'b1;
        state_d    = ST_FRAME;
      end
      ST_FRAME: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_bit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_fetch_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fetch |-> !status_i.empty)
    else $error("fetch from an empty queue");

  a_fetch_then_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |=> (state_q == ST_FRAME))
    else $error("fetch not followed by frame");
`endif

endmodule
